>>> rtl/core/lpht_pkg.sv
// lpht_pkg: shared types and constants of the linear probing hash table
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  localparam int TABLE_SIZE_DEF = 32;
  localparam int KEY_WIDTH_DEF  = 16;
  localparam int IN_KEY_W       = 16;
  localparam int SLOT_W         = 5;
  localparam int OUT_DATA_W     = 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO_KEY  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_READ,
    S_CHECK,
    S_RESULT
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/lpht_home.sv
// lpht_home: home slot unit, key modulo table size in three stages
// reciprocal multiply, back multiply and subtract, one correction; uses lpht_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpht_home
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [KEY_WIDTH-1:0]          key,
  output logic                               home_valid,
  output logic [$clog2(TABLE_SIZE)-1:0]      home
);

  localparam int          AW    = $clog2(TABLE_SIZE);
  localparam int          TW    = $clog2(TABLE_SIZE + 1);
  localparam int          PW    = KEY_WIDTH + 32;
  localparam int          DW    = KEY_WIDTH + TW;
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TABLE_SIZE);
  localparam logic [TW-1:0] TSZ = TW'(TABLE_SIZE);

  logic                  v1_r, v2_r, v3_r;
  logic [PW-1:0]         prod_r;
  logic [KEY_WIDTH-1:0]  key1_r;
  logic [KEY_WIDTH-1:0]  quot;
  logic [DW-1:0]         back;
  logic [DW-1:0]         diff;
  logic [AW:0]           rem_r;
  logic [AW:0]           rem_fix;
  logic [AW-1:0]         home_r;

  assign quot = prod_r[PW-1:32];
  assign back = DW'(quot) * DW'(TSZ);
  assign diff = DW'(key1_r) - back;

  always_comb begin
    if (rem_r >= (AW+1)'(TABLE_SIZE)) begin
      rem_fix = rem_r - (AW+1)'(TABLE_SIZE);
    end else begin
      rem_fix = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(key) * PW'(RECIP);
    key1_r <= key;
    rem_r  <= diff[AW:0];
    home_r <= rem_fix[AW-1:0];
  end

  assign home_valid = v3_r;
  assign home       = home_r;

endmodule

`default_nettype wire

>>> rtl/core/lpht_store.sv
// lpht_store: slot memory, one write port and one read port
// read data registered; uses lpht_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpht_store
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
  input  wire logic [KEY_WIDTH-1:0]          wr_data,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
  output logic [KEY_WIDTH-1:0]               rd_data
);

  logic [KEY_WIDTH-1:0] mem [TABLE_SIZE];
  logic [KEY_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/core/lpht_ctrl.sv
// lpht_ctrl: probe sequencer, clearing sweep and result register
// drives lpht_home and lpht_store; uses lpht_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire op_t                           in_op,
  input  wire logic [IN_KEY_W-1:0]           in_key,
  output logic                               home_start,
  output logic [KEY_WIDTH-1:0]               home_key,
  input  wire logic                          home_valid,
  input  wire logic [$clog2(TABLE_SIZE)-1:0] home,
  output logic                               wr_en,
  output logic [$clog2(TABLE_SIZE)-1:0]      wr_addr,
  output logic [KEY_WIDTH-1:0]               wr_data,
  output logic                               rd_en,
  output logic [$clog2(TABLE_SIZE)-1:0]      rd_addr,
  input  wire logic [KEY_WIDTH-1:0]          rd_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output res_t                               out_res
);

  localparam int          AW   = $clog2(TABLE_SIZE);
  localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

  state_t               state_r, state_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [AW-1:0]        cnt_r, cnt_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  op_t                  op_r, op_nxt;
  res_t                 res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r, out_res_nxt;
  logic                 out_load;
  logic                 accept;
  logic [31:0]          key_ext;
  logic [KEY_WIDTH-1:0] key_eff;
  logic [31:0]          pos_ext;
  logic [SLOT_W-1:0]    pos_slot;
  logic [AW-1:0]        pos_inc;

  assign key_ext  = 32'(in_key);
  assign key_eff  = key_ext[KEY_WIDTH-1:0];
  assign pos_ext  = 32'(pos_r);
  assign pos_slot = pos_ext[SLOT_W-1:0];
  assign pos_inc  = (pos_r == LAST) ? '0 : pos_r + AW'(1);
  assign accept   = in_valid && in_ready;

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    op_nxt    = op_r;
    res_nxt   = res_r;
    case (state_r)
      S_CLEAR: begin
        pos_nxt = pos_inc;
        if (pos_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          key_nxt = key_eff;
          op_nxt  = in_op;
          if (key_eff == '0) begin
            res_nxt   = '{status: ST_ZERO_KEY, slot: '0};
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_HOME;
          end
        end
      end
      S_HOME: begin
        if (home_valid) begin
          pos_nxt   = home;
          cnt_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (rd_data == '0) begin
          if (op_r == OP_INSERT) begin
            res_nxt = '{status: ST_INSERTED, slot: pos_slot};
          end else begin
            res_nxt = '{status: ST_NOT_FOUND, slot: '0};
          end
          state_nxt = S_RESULT;
        end else if (op_r == OP_SEARCH && rd_data == key_r) begin
          res_nxt   = '{status: ST_FOUND, slot: pos_slot};
          state_nxt = S_RESULT;
        end else if (cnt_r == LAST) begin
          if (op_r == OP_INSERT) begin
            res_nxt = '{status: ST_FULL, slot: '0};
          end else begin
            res_nxt = '{status: ST_NOT_FOUND, slot: '0};
          end
          state_nxt = S_RESULT;
        end else begin
          pos_nxt   = pos_inc;
          cnt_nxt   = cnt_r + AW'(1);
          state_nxt = S_READ;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_data    = key_r;
    out_load   = 1'b0;
    home_start = 1'b0;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        home_start = in_valid && (key_eff != '0);
      end
      S_READ: begin
        rd_en = 1'b1;
      end
      S_CHECK: begin
        wr_en = (op_r == OP_INSERT) && (rd_data == '0);
      end
      S_RESULT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign home_key = key_eff;
  assign wr_addr  = pos_r;
  assign rd_addr  = pos_r;

  always_comb begin
    out_res_nxt = out_res_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    op_r      <= op_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

>>> rtl/core/linear_probe_hash_table.sv
// channel | dir | tdata                      | tuser
// in      | in  | [15:0] key                 | [0] opcode (0 insert, 1 search)
// out     | out | [4:0] slot, [7:5] zero     | [2:0] status
//
// an item passes the home slot unit, then takes one memory read and one compare
// per probe on the single read port; a zero key goes straight to its result
// after reset a clearing sweep writes every slot empty, and in_tready stays
// low until it ends
// one item at a time; a result waits in the output register while the next
// item is taken, a stalled output holds the sequencer only at its result step
// top level: instantiates lpht_ctrl, lpht_home, lpht_store; uses lpht_pkg
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_KEY_W-1:0]   in_tdata,   // [15:0] key
  input  wire logic                  in_tuser,   // [0] opcode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [4:0] slot, [7:5] zero
  output logic [2:0]                 out_tuser   // [2:0] status
);

  localparam int AW = $clog2(TABLE_SIZE);

  logic                 home_start;
  logic [KEY_WIDTH-1:0] home_key;
  logic                 home_valid;
  logic [AW-1:0]        home;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;
  res_t                 out_res;
  op_t                  in_op;

  assign in_op = op_t'(in_tuser);

  lpht_ctrl #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_op),
    .in_key     (in_tdata),
    .home_start (home_start),
    .home_key   (home_key),
    .home_valid (home_valid),
    .home       (home),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  lpht_home #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_home (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (home_start),
    .key        (home_key),
    .home_valid (home_valid),
    .home       (home)
  );

  lpht_store #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_tdata = {(OUT_DATA_W - SLOT_W)'(0), out_res.slot};
  assign out_tuser = out_res.status;

endmodule

`default_nettype wire

>>> rtl/core/lpht_checker.sv
// lpht_checker: port level assertions of the hash table, bound to the top level
// uses lpht_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpht_checker
  import lpht_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [2:0]            out_tuser
);

  // one item in flight: ready drops right after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after an accepted beat");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= 3'(ST_ZERO_KEY))
    else $error("status code out of range");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == 3'(ST_NOT_FOUND) || out_tuser == 3'(ST_FULL) ||
                   out_tuser == 3'(ST_ZERO_KEY)) |-> out_tdata == '0)
    else $error("slot nonzero on a miss, full or zero key result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

`default_nettype wire

>>> tb/lpht_lookup_checker.sv
// lpht_lookup_checker: watches both streams of the hash table, keeps its own copy of the
// slot store, predicts status and slot of every accepted request and compares results
// depends on lpht_pkg
`timescale 1ns / 1ps

module lpht_lookup_checker
  import lpht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_KEY_W-1:0]   in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [2:0]            out_tuser,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int TABLE_SIZE = TABLE_SIZE_DEF;
  localparam int KEY_WIDTH  = KEY_WIDTH_DEF;
  localparam logic [IN_KEY_W-1:0] KEY_MASK =
    {IN_KEY_W{1'b1}} >> ((KEY_WIDTH >= IN_KEY_W) ? 0 : IN_KEY_W - KEY_WIDTH);

  logic [IN_KEY_W-1:0] slot_keys [TABLE_SIZE];
  res_t                expected_results [$];
  res_t                want;
  int                  mismatch_count = 0;

  // walk from the home slot, updating the shadow store on insert
  function automatic res_t probe_table(input op_t op, input logic [IN_KEY_W-1:0] key_in);
    logic [IN_KEY_W-1:0] key;
    int                  pos;
    res_t                r;
    key      = key_in & KEY_MASK;
    r.status = ST_ZERO_KEY;
    r.slot   = '0;
    if (key == '0) return r;
    pos = int'(key) % TABLE_SIZE;
    for (int n = 0; n < TABLE_SIZE; n++) begin
      if (op == OP_INSERT) begin
        if (slot_keys[pos] == '0) begin
          slot_keys[pos] = key;
          r.status = ST_INSERTED;
          r.slot   = pos[SLOT_W-1:0];
          return r;
        end
      end else begin
        if (slot_keys[pos] == '0) break;
        if (slot_keys[pos] == key) begin
          r.status = ST_FOUND;
          r.slot   = pos[SLOT_W-1:0];
          return r;
        end
      end
      pos = (pos + 1) % TABLE_SIZE;
    end
    r.status = (op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      for (int i = 0; i < TABLE_SIZE; i++) slot_keys[i] = '0;
    end else begin
      // result beat first: it always belongs to an older request
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at %0t: unexpected result status %0d data 0x%02h",
                     $realtime, out_tuser, out_tdata);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser != want.status ||
              out_tdata != {{(OUT_DATA_W-SLOT_W){1'b0}}, want.slot}) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch at %0t: status exp %0d got %0d, data exp 0x%02h got 0x%02h",
                       $realtime, want.status, out_tuser,
                       {{(OUT_DATA_W-SLOT_W){1'b0}}, want.slot}, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(probe_table(op_t'(in_tuser), in_tdata));
    end
    mismatches  <= mismatch_count;
    outstanding <= expected_results.size();
  end

endmodule

>>> tb/tb_top.sv
// tb_top: drives insert and search beats into linear_probe_hash_table with bursty input
// and a stalling output, and gives the verdict from lpht_lookup_checker
// depends on lpht_pkg, linear_probe_hash_table, lpht_lookup_checker
`timescale 1ns / 1ps

module tb_top;
  import lpht_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 930;

  typedef struct {
    op_t                 op;
    logic [IN_KEY_W-1:0] key;
  } lookup_req_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_KEY_W-1:0]   in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  int                    mismatches;
  int                    outstanding;
  int                    cycle_count = 0;
  int                    rx_mode     = 0;
  int                    rx_left     = 0;
  int                    rx_phase    = 0;

  lookup_req_t           requests [$];
  logic [IN_KEY_W-1:0]   inserted_keys [$];

  linear_probe_hash_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  lpht_lookup_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // output stall pattern: modes of random length
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= (rx_phase + 1) % 3;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= (rx_phase != 0);
      2: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic void add_req(input op_t op, input logic [IN_KEY_W-1:0] key);
    lookup_req_t req;
    req.op  = op;
    req.key = key;
    requests.push_back(req);
    if (op == OP_INSERT && key != '0) inserted_keys.push_back(key);
  endfunction

  // keys whose home sits near the wrap point, to build long clusters
  function automatic logic [IN_KEY_W-1:0] crowded_key();
    logic [IN_KEY_W-1:0] k;
    k      = IN_KEY_W'($urandom);
    k[4:0] = 5'(($urandom_range(0, 5) + 29) % 32);
    return k;
  endfunction

  task automatic send_req(input lookup_req_t req);
    in_tvalid <= 1'b1;
    in_tdata  <= req.key;
    in_tuser  <= req.op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    int                  idx;
    int                  burst;
    int                  gap;
    int                  pick;
    logic [IN_KEY_W-1:0] k;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero key, empty search, wrap at the top slot, collisions, bit extremes
    add_req(OP_INSERT, 16'h0000);
    add_req(OP_SEARCH, 16'h0000);
    add_req(OP_SEARCH, 16'h1234);
    add_req(OP_INSERT, 16'hFFFF);
    add_req(OP_INSERT, 16'hFFFF);
    add_req(OP_SEARCH, 16'hFFFF);
    add_req(OP_INSERT, 16'h001F);
    add_req(OP_SEARCH, 16'h001F);
    add_req(OP_SEARCH, 16'h003F);
    add_req(OP_INSERT, 16'h0001);
    add_req(OP_INSERT, 16'h8000);
    add_req(OP_SEARCH, 16'h8000);
    add_req(OP_SEARCH, 16'h0020);
    add_req(OP_SEARCH, 16'h0001);
    add_req(OP_INSERT, 16'h5555);
    add_req(OP_INSERT, 16'hAAAA);
    add_req(OP_SEARCH, 16'hAAAA);
    add_req(OP_SEARCH, 16'h7FFF);
    add_req(OP_INSERT, 16'h7FFF);
    add_req(OP_SEARCH, 16'h5555);

    // random: searches dominate so the table fills part way through the run,
    // leaving a long stretch with a full table
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        add_req(op_t'($urandom_range(0, 1)), '0);
      end else if (pick < 9) begin
        case ($urandom_range(0, 3))
          0: k = crowded_key();
          1: k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
          default: k = IN_KEY_W'($urandom);
        endcase
        add_req(OP_INSERT, k);
      end else begin
        case ($urandom_range(0, 3))
          0, 1: k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
          2: k = crowded_key();
          default: k = IN_KEY_W'($urandom);
        endcase
        add_req(OP_SEARCH, k);
      end
    end

    idx = 0;
    while (idx < requests.size()) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && idx < requests.size(); b++) begin
        send_req(requests[idx]);
        idx++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    // let the count of the last accepted beat settle
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> linear_probe_hash_table.f
rtl/core/lpht_pkg.sv
rtl/core/lpht_home.sv
rtl/core/lpht_store.sv
rtl/core/lpht_ctrl.sv
rtl/core/linear_probe_hash_table.sv
rtl/core/lpht_checker.sv
tb/lpht_lookup_checker.sv
tb/tb_top.sv
